FILE: rtl/gra_pkg.sv
// gra_pkg: shared types and constants of the grid rectangle allocator.
// Holds the controller states, status and function codes, and the command and
// status structs that join gra_ctrl and gra_dp. Depends on nothing.
package gra_pkg;

	localparam int COLS  = 16;
	localparam int ROWS  = 16;
	localparam int ITEMS = 64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_DISPATCH,
		ST_SRCH,
		ST_SRCH_END,
		ST_PL_CHK,
		ST_MV_LIFT,
		ST_MV_CHK,
		ST_PUT,
		ST_RM_FREE,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		RS_OK       = 3'd0,
		RS_NOSPACE  = 3'd1,
		RS_BOUNDS   = 3'd2,
		RS_OCCUPIED = 3'd3,
		RS_UNKNOWN  = 3'd4,
		RS_INUSE    = 3'd5,
		RS_BADSIZE  = 3'd6
	} status_t;

	localparam logic [2:0] FN_ADD    = 3'd0;
	localparam logic [2:0] FN_PLACE  = 3'd1;
	localparam logic [2:0] FN_REMOVE = 3'd2;
	localparam logic [2:0] FN_MOVE   = 3'd3;
	localparam logic [2:0] FN_QUERY  = 3'd4;
	localparam logic [2:0] FN_CLEAR  = 3'd5;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_MODE   = 2'd2;

	typedef enum logic [1:0] {POS_HOLD, POS_ANCHOR, POS_REC, POS_BEST} pos_op_t;
	typedef enum logic [2:0] {ROT_HOLD, ROT_RIN, ROT_REC, ROT_TOGGLE, ROT_CLEAR} rot_op_t;
	typedef enum logic [1:0] {FT_HOLD, FT_ADD, FT_SUB} ft_op_t;

	typedef struct packed {
		logic [3:0] x;
		logic [3:0] y;
		logic       rot;
		logic [4:0] w;
		logic [4:0] h;
	} rec_t;

	typedef struct packed {
		logic    item_ld;
		logic    div_step;
		logic    base_item;
		logic    base_rec;
		pos_op_t pos_op;
		rot_op_t rot_op;
		logic    row_clr;
		logic    row_inc;
		logic    fill_en;
		logic    fill_occ;
		logic    rec_wr;
		logic    rec_inv;
		ft_op_t  ft_op;
		logic    srch_clr;
		logic    srch_step;
		logic    clr_all;
		logic    res_ld;
		status_t res_st;
		logic    res_place;
		logic    res_query;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       div_last;
		logic       size_zero;
		logic       tag_valid;
		logic       anchor_bad;
		logic       same_anchor;
		logic       allow;
		logic       square;
		logic       rot;
		logic       bounds_bad;
		logic       row_fit;
		logic       last_row;
		logic       srch_last;
		logic       found;
		logic       out_free;
	} sts_t;

endpackage

FILE: rtl/gra_ctrl.sv
// gra_ctrl: sequencer of the grid rectangle allocator.
// Steps a beat through divide, dispatch and, by function, search, check, lift, fill or free phases.
// Depends on gra_pkg; drives gra_dp through cmd_t and reads sts_t.
module gra_ctrl import gra_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t  state_q, state_nx;
	status_t st_q, st_nx;
	logic    place_q, place_nx;
	logic    query_q, query_nx;
	logic    try2_q, try2_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			st_q    <= RS_OK;
			place_q <= 1'b0;
			query_q <= 1'b0;
			try2_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			st_q    <= st_nx;
			place_q <= place_nx;
			query_q <= query_nx;
			try2_q  <= try2_nx;
		end
	end

	always_comb begin
		cmd       = '0;
		cmd.res_st = st_q;
		state_nx  = state_q;
		st_nx     = st_q;
		place_nx  = place_q;
		query_nx  = query_q;
		try2_nx   = try2_q;
		in_ready  = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.item_ld = 1'b1;
					state_nx    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				st_nx    = RS_OK;
				place_nx = 1'b0;
				query_nx = 1'b0;
				try2_nx  = 1'b0;
				state_nx = ST_FINISH;
				case (sts.func)
					FN_ADD, FN_PLACE: begin
						if (sts.size_zero) st_nx = RS_BADSIZE;
						else if (sts.tag_valid) st_nx = RS_INUSE;
						else if (sts.func == FN_ADD) begin
							cmd.base_item = 1'b1;
							cmd.rot_op    = ROT_CLEAR;
							cmd.srch_clr  = 1'b1;
							state_nx      = ST_SRCH;
						end else if (sts.anchor_bad) st_nx = RS_BOUNDS;
						else begin
							cmd.base_item = 1'b1;
							cmd.pos_op    = POS_ANCHOR;
							cmd.rot_op    = ROT_RIN;
							cmd.row_clr   = 1'b1;
							state_nx      = ST_PL_CHK;
						end
					end
					FN_REMOVE: begin
						if (!sts.tag_valid) st_nx = RS_UNKNOWN;
						else begin
							cmd.base_rec = 1'b1;
							cmd.pos_op   = POS_REC;
							cmd.rot_op   = ROT_REC;
							cmd.row_clr  = 1'b1;
							state_nx     = ST_RM_FREE;
						end
					end
					FN_MOVE: begin
						if (!sts.tag_valid) st_nx = RS_UNKNOWN;
						else if (sts.anchor_bad) st_nx = RS_BOUNDS;
						else begin
							cmd.base_rec = 1'b1;
							cmd.pos_op   = POS_REC;
							cmd.rot_op   = ROT_REC;
							cmd.row_clr  = 1'b1;
							if (sts.same_anchor && !sts.allow) place_nx = 1'b1;
							else state_nx = ST_MV_LIFT;
						end
					end
					FN_QUERY: begin
						if (sts.anchor_bad) st_nx = RS_BOUNDS;
						else query_nx = 1'b1;
					end
					FN_CLEAR: cmd.clr_all = 1'b1;
					default: ;
				endcase
			end
			ST_SRCH: begin
				cmd.srch_step = 1'b1;
				if (sts.srch_last) state_nx = ST_SRCH_END;
			end
			ST_SRCH_END: begin
				if (sts.found) begin
					cmd.pos_op  = POS_BEST;
					cmd.row_clr = 1'b1;
					place_nx    = 1'b1;
					state_nx    = ST_PUT;
				end else if (!sts.rot && sts.allow && !sts.square) begin
					cmd.rot_op   = ROT_TOGGLE;
					cmd.srch_clr = 1'b1;
					state_nx     = ST_SRCH;
				end else begin
					st_nx    = RS_NOSPACE;
					state_nx = ST_FINISH;
				end
			end
			ST_PL_CHK: begin
				if (sts.bounds_bad) begin
					st_nx    = RS_BOUNDS;
					state_nx = ST_FINISH;
				end else if (!sts.row_fit) begin
					st_nx    = RS_OCCUPIED;
					state_nx = ST_FINISH;
				end else if (sts.last_row) begin
					cmd.row_clr = 1'b1;
					place_nx    = 1'b1;
					state_nx    = ST_PUT;
				end else cmd.row_inc = 1'b1;
			end
			ST_MV_LIFT: begin
				cmd.fill_en = 1'b1;
				cmd.row_inc = 1'b1;
				if (sts.last_row) begin
					cmd.ft_op   = FT_ADD;
					cmd.pos_op  = POS_ANCHOR;
					cmd.row_clr = 1'b1;
					state_nx    = ST_MV_CHK;
				end
			end
			ST_MV_CHK: begin
				if (sts.bounds_bad || !sts.row_fit) begin
					cmd.row_clr = 1'b1;
					if (!try2_q && sts.allow) begin
						cmd.rot_op = ROT_TOGGLE;
						try2_nx    = 1'b1;
					end else begin
						st_nx      = sts.bounds_bad ? RS_BOUNDS : RS_OCCUPIED;
						cmd.pos_op = POS_REC;
						cmd.rot_op = ROT_REC;
						place_nx   = 1'b1;
						state_nx   = ST_PUT;
					end
				end else if (sts.last_row) begin
					cmd.row_clr = 1'b1;
					place_nx    = 1'b1;
					state_nx    = ST_PUT;
				end else cmd.row_inc = 1'b1;
			end
			ST_PUT: begin
				cmd.fill_en  = 1'b1;
				cmd.fill_occ = 1'b1;
				cmd.row_inc  = 1'b1;
				if (sts.last_row) begin
					cmd.rec_wr = 1'b1;
					cmd.ft_op  = FT_SUB;
					state_nx   = ST_FINISH;
				end
			end
			ST_RM_FREE: begin
				cmd.fill_en = 1'b1;
				cmd.row_inc = 1'b1;
				if (sts.last_row) begin
					cmd.ft_op   = FT_ADD;
					cmd.rec_inv = 1'b1;
					state_nx    = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.res_ld    = 1'b1;
					cmd.res_place = place_q;
					cmd.res_query = query_q;
					state_nx      = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

FILE: rtl/gra_dp.sv
// gra_dp: datapath of the grid rectangle allocator.
// Holds configuration, occupancy rows, owner and record stores, the anchor
// divider, the row-run search and the result register. Depends on gra_pkg.
module gra_dp import gra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	input  logic [2:0]  in_func,
	input  logic [25:0] in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_data,
	input  cmd_t        cmd,
	output sts_t        sts
);

	logic [4:0]  gw_q, gh_q;
	logic        mode_q, clr_pend_q;
	logic [4:0]  ew, eh;
	logic [8:0]  cells;
	logic        cfg_wr;

	logic [2:0]  func_q;
	logic [5:0]  tag_q;
	logic [4:0]  iw_q, ih_q;
	logic [7:0]  anchor_q;
	logic        allow_q, rin_q;

	logic [7:0]  dv_q;
	logic [3:0]  rem_q;
	logic [2:0]  div_cnt_q;
	logic [4:0]  div_t;

	logic [ITEMS-1:0]  valid_q;
	rec_t              rec_mem [ITEMS];
	rec_t              rec_rd_q;
	logic [COLS-1:0]   free_q [ROWS];
	logic [COLS-1:0][5:0] owner_mem [ROWS];
	logic [COLS-1:0][5:0] owner_rd_q;

	logic [3:0]  cx_q, cy_q, j_q;
	logic [4:0]  bw_q, bh_q;
	logic        rot_q;
	logic [4:0]  cw, ch;
	logic [31:0] wmask;
	logic [15:0] rmask;
	logic [3:0]  row_idx;
	logic [9:0]  area;

	logic [4:0]  run_q [COLS];
	logic [4:0]  run_nx [COLS];
	logic [COLS-1:0] fitcol, hit;
	logic [3:0]  hx;
	logic        any_hit;
	logic [3:0]  sy_q;
	logic [4:0]  y0, score;
	logic        found_q;
	logic [3:0]  bx_q, by_q;
	logic [4:0]  bscore_q;

	logic [8:0]  free_total_q;
	logic [8:0]  pidx9;
	logic        q_occ;
	logic [5:0]  q_own;
	logic        out_valid_q;
	logic [31:0] out_data_q;

	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gw_q       <= 5'(COLS);
			gh_q       <= 5'(ROWS);
			mode_q     <= 1'b0;
			clr_pend_q <= 1'b0;
		end else begin
			clr_pend_q <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_WIDTH: begin
						gw_q       <= pwdata[4:0];
						clr_pend_q <= 1'b1;
					end
					REG_HEIGHT: begin
						gh_q       <= pwdata[4:0];
						clr_pend_q <= 1'b1;
					end
					REG_MODE: mode_q <= pwdata[0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:  prdata = {27'd0, gw_q};
			REG_HEIGHT: prdata = {27'd0, gh_q};
			REG_MODE:   prdata = {31'd0, mode_q};
			default:    prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (gw_q == 5'd0) ew = 5'd1;
		else if (gw_q > 5'(COLS)) ew = 5'(COLS);
		else ew = gw_q;
		if (gh_q == 5'd0) eh = 5'd1;
		else if (gh_q > 5'(ROWS)) eh = 5'(ROWS);
		else eh = gh_q;
	end

	assign cells = 9'({4'd0, ew} * {4'd0, eh});

	// beat capture and anchor divider
	assign div_t = {rem_q, dv_q[7]};

	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			func_q    <= in_func;
			tag_q     <= in_data[5:0];
			iw_q      <= in_data[10:6];
			ih_q      <= in_data[15:11];
			anchor_q  <= in_data[23:16];
			allow_q   <= in_data[24];
			rin_q     <= in_data[25];
			dv_q      <= in_data[23:16];
			rem_q     <= 4'd0;
			div_cnt_q <= 3'd0;
		end else if (cmd.div_step) begin
			if (div_t >= ew) begin
				rem_q <= 4'(div_t - ew);
				dv_q  <= {dv_q[6:0], 1'b1};
			end else begin
				rem_q <= div_t[3:0];
				dv_q  <= {dv_q[6:0], 1'b0};
			end
			div_cnt_q <= div_cnt_q + 3'd1;
		end
	end

	// working rectangle
	assign cw      = rot_q ? bh_q : bw_q;
	assign ch      = rot_q ? bw_q : bh_q;
	assign wmask   = (32'd1 << cw) - 32'd1;
	assign rmask   = wmask[15:0] << cx_q;
	assign row_idx = cy_q + j_q;
	assign area    = {5'd0, cw} * {5'd0, ch};

	always_ff @(posedge clk) begin
		if (cmd.base_item) begin
			bw_q <= iw_q;
			bh_q <= ih_q;
		end else if (cmd.base_rec) begin
			bw_q <= rec_rd_q.w;
			bh_q <= rec_rd_q.h;
		end
		case (cmd.pos_op)
			POS_ANCHOR: begin
				cx_q <= rem_q;
				cy_q <= dv_q[3:0];
			end
			POS_REC: begin
				cx_q <= rec_rd_q.x;
				cy_q <= rec_rd_q.y;
			end
			POS_BEST: begin
				cx_q <= bx_q;
				cy_q <= by_q;
			end
			default: ;
		endcase
		case (cmd.rot_op)
			ROT_RIN:    rot_q <= rin_q;
			ROT_REC:    rot_q <= rec_rd_q.rot;
			ROT_TOGGLE: rot_q <= ~rot_q;
			ROT_CLEAR:  rot_q <= 1'b0;
			default: ;
		endcase
		if (cmd.row_clr) j_q <= 4'd0;
		else if (cmd.row_inc) j_q <= j_q + 4'd1;
	end

	// occupancy rows, record valid bits and free count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < ROWS; r++) free_q[r] <= '1;
			valid_q      <= '0;
			free_total_q <= 9'(COLS * ROWS);
		end else if (cmd.clr_all || clr_pend_q) begin
			for (int r = 0; r < ROWS; r++) free_q[r] <= '1;
			valid_q      <= '0;
			free_total_q <= cells;
		end else begin
			if (cmd.fill_en) begin
				free_q[row_idx] <= cmd.fill_occ ? (free_q[row_idx] & ~rmask)
				                                : (free_q[row_idx] | rmask);
			end
			if (cmd.rec_wr) valid_q[tag_q] <= 1'b1;
			if (cmd.rec_inv) valid_q[tag_q] <= 1'b0;
			case (cmd.ft_op)
				FT_ADD:  free_total_q <= free_total_q + area[8:0];
				FT_SUB:  free_total_q <= free_total_q - area[8:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rec_wr) rec_mem[tag_q] <= '{x: cx_q, y: cy_q, rot: rot_q, w: bw_q, h: bh_q};
		rec_rd_q <= rec_mem[tag_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_en && cmd.fill_occ) begin
			for (int x = 0; x < COLS; x++) begin
				if (rmask[x]) owner_mem[row_idx][x] <= tag_q;
			end
		end
		owner_rd_q <= owner_mem[dv_q[3:0]];
	end

	// row-run search: run_q counts stacked rows in which each column fits
	always_comb begin
		for (int x = 0; x < COLS; x++) begin
			fitcol[x] = (((free_q[sy_q] >> x) & wmask[15:0]) == wmask[15:0]) &&
			            ((6'(x) + {1'b0, cw}) <= {1'b0, ew});
			run_nx[x] = fitcol[x] ? run_q[x] + 5'd1 : 5'd0;
			hit[x]    = (run_nx[x] >= ch);
		end
	end

	always_comb begin
		hx      = 4'd0;
		any_hit = (hit != '0);
		for (int x = COLS - 1; x >= 0; x--) begin
			if (hit[x]) hx = 4'(x);
		end
	end

	assign y0    = {1'b0, sy_q} + 5'd1 - ch;
	assign score = {1'b0, hx} + y0;

	always_ff @(posedge clk) begin
		if (cmd.srch_clr) begin
			for (int x = 0; x < COLS; x++) run_q[x] <= 5'd0;
			sy_q    <= 4'd0;
			found_q <= 1'b0;
		end else if (cmd.srch_step) begin
			for (int x = 0; x < COLS; x++) run_q[x] <= run_nx[x];
			sy_q <= sy_q + 4'd1;
			if (any_hit && (!found_q || score < bscore_q)) begin
				found_q  <= 1'b1;
				bx_q     <= hx;
				by_q     <= y0[3:0];
				bscore_q <= score;
			end
		end
	end

	// result register
	assign pidx9 = 9'({5'd0, cy_q} * {4'd0, ew}) + {5'd0, cx_q};
	assign q_occ = cmd.res_query & ~free_q[dv_q[3:0]][rem_q];
	assign q_own = q_occ ? owner_rd_q[rem_q] : 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.res_ld) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			out_data_q <= {4'd0, free_total_q, q_occ, q_own,
			               cmd.res_place & rot_q,
			               cmd.res_place ? pidx9[7:0] : 8'd0,
			               cmd.res_st};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_comb begin
		sts.func        = func_q;
		sts.div_last    = (div_cnt_q == 3'd7);
		sts.size_zero   = (iw_q == 5'd0) || (ih_q == 5'd0);
		sts.tag_valid   = valid_q[tag_q];
		sts.anchor_bad  = ({1'b0, anchor_q} >= cells);
		sts.same_anchor = (rec_rd_q.x == rem_q) && (rec_rd_q.y == dv_q[3:0]);
		sts.allow       = allow_q;
		sts.square      = (iw_q == ih_q);
		sts.rot         = rot_q;
		sts.bounds_bad  = (({2'd0, cx_q} + {1'b0, cw}) > {1'b0, ew}) ||
		                  (({2'd0, cy_q} + {1'b0, ch}) > {1'b0, eh});
		sts.row_fit     = ((free_q[row_idx] & rmask) == rmask);
		sts.last_row    = (({1'b0, j_q} + 5'd1) == ch);
		sts.srch_last   = ((mode_q == 1'b0) && any_hit) || ({1'b0, sy_q} == eh - 5'd1);
		sts.found       = found_q;
		sts.out_free    = ~out_valid_q | out_ready;
	end

endmodule

FILE: rtl/grid_rectangle_allocator_top.sv
// Every beat passes through the anchor divider and dispatch; query, clear and
// rejected beats then go to the result; place checks and then fills one row per
// cycle, remove frees one row per cycle, move lifts, checks and refills row by
// row; add scans one grid row per cycle per orientation, up to the grid height.
// Throughput: one beat at a time; the next beat is taken once the result is
// in the output register. Reset clears every cell and record at once.
module grid_rectangle_allocator_top import gra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tag[5:0], item_width[10:6], item_height[15:11], anchor_index[23:16],
	// allow_rotation[24], rotated_in[25]
	input  logic [31:0] s_axis_tdata,
	// func[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[2:0], placed_index[10:3], placed_rotated[11], owner_tag[17:12],
	// cell_occupied[18], free_count[27:19]
	output logic [31:0] m_axis_tdata
);

	cmd_t cmd;
	sts_t sts;

	assign pready = 1'b1;

	gra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	gra_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.in_func   (s_axis_tuser),
		.in_data   (s_axis_tdata[25:0]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: rtl/gra_chk.sv
// gra_chk: port-level checks of the grid rectangle allocator.
// Bound to grid_rectangle_allocator_top; depends on gra_pkg.
module gra_chk import gra_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second beat taken while one is at work");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[27:19] <= 9'(COLS * ROWS) && m_axis_tdata[2:0] != 3'd7)
		else $error("free count or status out of range");

	a_occ_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[18] |-> m_axis_tdata[2:0] == RS_OK)
		else $error("occupied flag on a failed beat");

endmodule

bind grid_rectangle_allocator_top gra_chk u_gra_chk (.*);

FILE: bench/tb_grid_rectangle_allocator_top.sv
// Testbench of grid_rectangle_allocator_top: drives allocator commands over the
// stream port and grid settings over the APB port, predicts every result in a
// scoreboard class and checks it. Depends on gra_pkg and the RTL.
`timescale 1ns / 100ps

module tb_grid_rectangle_allocator_top;
	import gra_pkg::*;

	typedef struct {
		logic [2:0] func;
		logic [5:0] tag;
		logic [4:0] iw;
		logic [4:0] ih;
		logic [7:0] anchor;
		logic       allow;
		logic       rin;
	} cmd_beat_t;

	typedef struct packed {
		logic [2:0] st;
		logic [7:0] pidx;
		logic       prot;
		logic [5:0] own;
		logic       occ;
		logic [8:0] freec;
	} res_beat_t;

	class grid_scoreboard;
		int unsigned gw_reg, gh_reg, mode;
		bit          cell_free [256];
		logic [5:0]  owner [256];
		bit          rv [64];
		int unsigned ra [64], rw [64], rh [64];
		bit          rr [64];
		int unsigned free_cells;
		res_beat_t   pending [$];
		int          errors, checked;

		function int unsigned gwe();
			return (gw_reg == 0) ? 1 : (gw_reg > COLS ? COLS : gw_reg);
		endfunction

		function int unsigned ghe();
			return (gh_reg == 0) ? 1 : (gh_reg > ROWS ? ROWS : gh_reg);
		endfunction

		function void wipe();
			for (int i = 0; i < 256; i++) begin
				cell_free[i] = 1'b1;
				owner[i] = '0;
			end
			for (int i = 0; i < 64; i++)
				rv[i] = 1'b0;
			free_cells = gwe() * ghe();
		endfunction

		function void reset_state();
			gw_reg = 16;
			gh_reg = 16;
			mode = 0;
			wipe();
		endfunction

		function void write_reg(int unsigned idx, int unsigned val);
			if (idx == REG_WIDTH) begin
				gw_reg = val & 31;
				wipe();
			end else if (idx == REG_HEIGHT) begin
				gh_reg = val & 31;
				wipe();
			end else if (idx == REG_MODE)
				mode = val & 1;
		endfunction

		function logic [2:0] rect_fit(int unsigned x, int unsigned y, int unsigned w,
				int unsigned h);
			int unsigned g;
			g = gwe();
			if (x + w > g || y + h > ghe())
				return RS_BOUNDS;
			for (int j = 0; j < h; j++)
				for (int i = 0; i < w; i++)
					if (!cell_free[(y + j) * g + x + i])
						return RS_OCCUPIED;
			return RS_OK;
		endfunction

		function void paint(int unsigned a, int unsigned w, int unsigned h,
				logic [5:0] t, bit occ);
			int unsigned g, c;
			g = gwe();
			for (int j = 0; j < h; j++)
				for (int i = 0; i < w; i++) begin
					c = (a / g + j) * g + a % g + i;
					if (c < 256) begin
						cell_free[c] = !occ;
						owner[c] = occ ? t : 6'd0;
					end
				end
			if (occ)
				free_cells -= w * h;
			else
				free_cells += w * h;
		endfunction

		function bit scan(int unsigned w, int unsigned h, output int unsigned hit);
			int unsigned g, best, score;
			bit any;
			g = gwe();
			any = 1'b0;
			best = 0;
			score = 0;
			hit = 0;
			if (w > g || h > ghe())
				return 1'b0;
			for (int y = 0; y + h <= ghe(); y++)
				for (int x = 0; x + w <= g; x++) begin
					if (rect_fit(x, y, w, h) != RS_OK)
						continue;
					if (mode == 0) begin
						hit = y * g + x;
						return 1'b1;
					end
					if (!any || x + y < score) begin
						any = 1'b1;
						score = x + y;
						best = y * g + x;
					end
				end
			hit = best;
			return any;
		endfunction

		function void enter(logic [5:0] t, int unsigned a, bit r, int unsigned w,
				int unsigned h);
			rv[t] = 1'b1;
			ra[t] = a;
			rr[t] = r;
			rw[t] = w;
			rh[t] = h;
			paint(a, r ? h : w, r ? w : h, t, 1'b1);
		endfunction

		function void note_cmd(cmd_beat_t c);
			res_beat_t e;
			int unsigned g, cells, hit, w, h;
			bit ok, rot;
			g = gwe();
			cells = g * ghe();
			e = '0;
			e.st = RS_OK;
			w = c.iw;
			h = c.ih;
			if (c.func == FN_ADD || c.func == FN_PLACE) begin
				if (w == 0 || h == 0)
					e.st = RS_BADSIZE;
				else if (rv[c.tag])
					e.st = RS_INUSE;
				else if (c.func == FN_ADD) begin
					rot = 1'b0;
					ok = scan(w, h, hit);
					if (!ok && c.allow && w != h) begin
						ok = scan(h, w, hit);
						rot = ok;
					end
					if (!ok)
						e.st = RS_NOSPACE;
					else begin
						enter(c.tag, hit, rot, w, h);
						e.pidx = 8'(hit);
						e.prot = rot;
					end
				end else begin
					if (c.anchor >= cells)
						e.st = RS_BOUNDS;
					else
						e.st = rect_fit(c.anchor % g, c.anchor / g, c.rin ? h : w,
							c.rin ? w : h);
					if (e.st == RS_OK) begin
						enter(c.tag, c.anchor, c.rin, w, h);
						e.pidx = c.anchor;
						e.prot = c.rin;
					end
				end
			end else if (c.func == FN_REMOVE) begin
				if (!rv[c.tag])
					e.st = RS_UNKNOWN;
				else begin
					paint(ra[c.tag], rr[c.tag] ? rh[c.tag] : rw[c.tag],
						rr[c.tag] ? rw[c.tag] : rh[c.tag], c.tag, 1'b0);
					rv[c.tag] = 1'b0;
				end
			end else if (c.func == FN_MOVE) begin
				if (!rv[c.tag])
					e.st = RS_UNKNOWN;
				else if (c.anchor >= cells)
					e.st = RS_BOUNDS;
				else if (ra[c.tag] == c.anchor && !c.allow) begin
					e.pidx = 8'(ra[c.tag]);
					e.prot = rr[c.tag];
				end else begin
					int unsigned oa, ow, oh;
					bit orot;
					oa = ra[c.tag];
					ow = rw[c.tag];
					oh = rh[c.tag];
					orot = rr[c.tag];
					rot = orot;
					paint(oa, orot ? oh : ow, orot ? ow : oh, c.tag, 1'b0);
					e.st = rect_fit(c.anchor % g, c.anchor / g, rot ? oh : ow, rot ? ow : oh);
					if (e.st != RS_OK && c.allow) begin
						rot = !rot;
						e.st = rect_fit(c.anchor % g, c.anchor / g, rot ? oh : ow,
							rot ? ow : oh);
					end
					if (e.st == RS_OK) begin
						enter(c.tag, c.anchor, rot, ow, oh);
						e.pidx = c.anchor;
						e.prot = rot;
					end else begin
						enter(c.tag, oa, orot, ow, oh);
						e.pidx = 8'(oa);
						e.prot = orot;
					end
				end
			end else if (c.func == FN_QUERY) begin
				if (c.anchor >= cells)
					e.st = RS_BOUNDS;
				else if (!cell_free[c.anchor]) begin
					e.occ = 1'b1;
					e.own = owner[c.anchor];
				end
			end else if (c.func == FN_CLEAR)
				wipe();
			e.freec = free_cells[8:0];
			pending.push_back(e);
		endfunction

		function void check_res(logic [31:0] d);
			res_beat_t e, a;
			a.st = d[2:0];
			a.pidx = d[10:3];
			a.prot = d[11];
			a.own = d[17:12];
			a.occ = d[18];
			a.freec = d[27:19];
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, d);
				errors++;
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e != a || d[31:28] != 0) begin
				$display("%0t: mismatch exp st=%0d idx=%0d rot=%0d own=%0d occ=%0d free=%0d",
					$time, e.st, e.pidx, e.prot, e.own, e.occ, e.freec);
				$display("%0t:          act st=%0d idx=%0d rot=%0d own=%0d occ=%0d free=%0d",
					$time, a.st, a.pidx, a.prot, a.own, a.occ, a.freec);
				errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        psel, penable, pwrite, pready;
	logic [3:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [31:0] s_axis_tdata, m_axis_tdata;
	logic [2:0]  s_axis_tuser;

	grid_scoreboard sb;
	longint unsigned cycles;
	int sent;
	bit stall_heavy;

	grid_rectangle_allocator_top dut (.*);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("** grid_rectangle_allocator_top: FAILED **");
			$finish;
		end
	end

	// receiver: check accepted beats, stall on a phase-shifting pattern or, in heavy mode, at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready)
				sb.check_res(m_axis_tdata);
			if (stall_heavy)
				m_axis_tready <= ($urandom_range(0, 3) == 0);
			else
				m_axis_tready <= ((cycles % 29) < 22) || ($urandom_range(0, 1) == 1);
		end
	end

	task automatic apb_write(input logic [1:0] idx, input int unsigned val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic send(input cmd_beat_t c);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= c.func;
		s_axis_tdata <= {6'd0, c.rin, c.allow, c.anchor, c.ih, c.iw, c.tag};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_cmd(c);
		sent++;
	endtask

	task automatic gap();
		s_axis_tvalid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic cmd_beat_t mk(logic [2:0] f, logic [5:0] t, logic [4:0] w,
			logic [4:0] h, logic [7:0] a, logic al, logic r);
		cmd_beat_t c;
		c = '{f, t, w, h, a, al, r};
		return c;
	endfunction

	function automatic cmd_beat_t rand_cmd();
		cmd_beat_t c;
		int unsigned g, sel;
		g = sb.gwe() * sb.ghe();
		sel = $urandom_range(0, 99);
		c.tag = (sel < 70) ? 6'($urandom_range(0, 11)) : 6'($urandom_range(0, 63));
		c.iw = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 4));
		c.ih = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
			5'($urandom_range(1, 4));
		c.anchor = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) :
			8'($urandom_range(0, g - 1));
		c.allow = 1'($urandom_range(0, 1));
		c.rin = 1'($urandom_range(0, 1));
		sel = $urandom_range(0, 99);
		if (sel < 28)
			c.func = FN_ADD;
		else if (sel < 42)
			c.func = FN_PLACE;
		else if (sel < 58)
			c.func = FN_REMOVE;
		else if (sel < 76)
			c.func = FN_MOVE;
		else if (sel < 96)
			c.func = FN_QUERY;
		else if (sel < 98)
			c.func = FN_CLEAR;
		else
			c.func = 3'($urandom_range(6, 7));
		return c;
	endfunction

	task automatic run_random(input int n);
		int burst;
		burst = 0;
		for (int i = 0; i < n; i++) begin
			if (burst == 0) begin
				gap();
				burst = $urandom_range(1, 12);
			end
			send(rand_cmd());
			burst--;
		end
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles = 0;
		sent = 0;
		stall_heavy = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every function, special cases on the full grid
		send(mk(FN_ADD, 0, 16, 16, 0, 0, 0));
		send(mk(FN_QUERY, 0, 1, 1, 255, 0, 0));
		send(mk(FN_ADD, 1, 1, 1, 0, 1, 0));
		send(mk(FN_REMOVE, 0, 1, 1, 0, 0, 0));
		send(mk(FN_ADD, 1, 0, 3, 0, 0, 0));
		send(mk(FN_PLACE, 2, 5, 31, 0, 0, 0));
		send(mk(FN_ADD, 3, 17, 2, 0, 0, 0));
		send(mk(FN_ADD, 4, 3, 20, 0, 1, 0));
		send(mk(FN_PLACE, 5, 3, 2, 254, 0, 1));
		send(mk(FN_PLACE, 6, 4, 2, 17, 0, 1));
		send(mk(FN_PLACE, 7, 1, 1, 18, 1, 0));
		send(mk(FN_ADD, 6, 1, 1, 0, 0, 0));
		send(mk(FN_MOVE, 9, 1, 1, 0, 0, 0));
		send(mk(FN_MOVE, 6, 1, 1, 17, 0, 0));
		send(mk(FN_MOVE, 6, 1, 1, 17, 1, 0));
		send(mk(FN_MOVE, 6, 1, 1, 15, 0, 0));
		send(mk(FN_MOVE, 6, 1, 1, 15, 1, 0));
		send(mk(FN_QUERY, 63, 31, 31, 17, 1, 1));
		send(mk(FN_REMOVE, 63, 1, 1, 0, 0, 0));
		send(mk(FN_ADD, 63, 16, 15, 0, 1, 0));
		send(mk(FN_ADD, 8, 15, 16, 0, 1, 0));
		send(mk(3'd6, 0, 0, 0, 0, 0, 0));
		send(mk(3'd7, 63, 31, 31, 255, 1, 1));
		send(mk(FN_CLEAR, 0, 0, 0, 0, 0, 0));
		s_axis_tvalid <= 1'b0;
		drain();

		apb_write(REG_MODE, 1);
		run_random(250);
		drain();
		apb_write(REG_WIDTH, 5);
		apb_write(REG_HEIGHT, 7);
		run_random(200);
		drain();
		apb_write(REG_MODE, 0);
		apb_write(REG_WIDTH, 1);
		apb_write(REG_HEIGHT, 1);
		stall_heavy = 1;
		run_random(80);
		drain();
		apb_write(REG_WIDTH, 31);
		apb_write(REG_HEIGHT, 0);
		stall_heavy = 0;
		run_random(120);
		drain();
		apb_write(REG_WIDTH, 8);
		apb_write(REG_HEIGHT, 16);
		apb_write(REG_MODE, 1);
		run_random(200);
		drain();
		apb_write(REG_WIDTH, 16);
		apb_write(REG_HEIGHT, 16);
		apb_write(REG_MODE, 0);
		run_random(280);
		drain();

		$display("covered %0d commands over grids from 1x1 to 16x16 in both search modes,",
			sent);
		$display("%0d results compared, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** grid_rectangle_allocator_top: PASSED **");
		else
			$display("** grid_rectangle_allocator_top: FAILED **");
		$finish;
	end
endmodule
